// ===== hdl/sld_pkg.sv =====
// Shared types and constants for the sync/length deframer.
`timescale 1ns / 1ps
`default_nettype none

package sld_pkg;

  localparam logic [7:0] SYNC_FIRST  = 8'h55;
  localparam logic [7:0] SYNC_SECOND = 8'hAA;

  localparam logic [7:0] TYPE_NAME = 8'h01;
  localparam logic [7:0] TYPE_CHAT = 8'h02;
  localparam logic [7:0] TYPE_FILE = 8'h03;

  localparam logic [1:0] KIND_NAME    = 2'd0;
  localparam logic [1:0] KIND_CHAT    = 2'd1;
  localparam logic [1:0] KIND_FNAME   = 2'd2;
  localparam logic [1:0] KIND_CONTENT = 2'd3;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data_byte;
    logic       last;
    logic       empty_res;
  } res_t;

  // up to two results come out of one request
  typedef struct packed {
    logic [1:0] cnt;
    res_t       r0;
    res_t       r1;
  } push_t;

  function automatic res_t empty_result(input logic [1:0] kind);
    res_t r;
    r.kind      = kind;
    r.data_byte = 8'd0;
    r.last      = 1'b1;
    r.empty_res = 1'b1;
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/sld_parse.sv =====
// Frame parser: sync hunt, header collection and section byte counting.
`timescale 1ns / 1ps
`default_nettype none

module sld_parse (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          go_i,
  input  wire logic [7:0]    byte_i,
  output sld_pkg::push_t     push_o
);
  import sld_pkg::*;

  typedef enum logic [2:0] {
    PH_HUNT    = 3'd0,
    PH_SYNC1   = 3'd1,
    PH_HEADER  = 3'd2,
    PH_NAME    = 3'd3,
    PH_CHAT    = 3'd4,
    PH_FNAME   = 3'd5,
    PH_CONTENT = 3'd6
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [2:0]  idx_q, idx_d;
  logic [7:0]  type_q, type_d;
  logic [31:0] len_q, len_d;
  logic [7:0]  nlen_q, nlen_d;
  logic [31:0] rem_q, rem_d;
  logic [31:0] rem_dec;
  logic [1:0]  hsel;
  logic [2:0]  ph_off;
  logic [31:0] len_part;
  push_t       push;

  assign rem_dec  = rem_q - 32'd1;
  assign hsel     = idx_q[1:0] - 2'd3;
  assign len_part = {24'd0, byte_i} << {hsel, 3'b000};
  assign ph_off   = phase_q - PH_NAME;

  always_comb begin
    phase_d = phase_q;
    idx_d   = idx_q;
    type_d  = type_q;
    len_d   = len_q;
    nlen_d  = nlen_q;
    rem_d   = rem_q;
    push    = '0;
    case (phase_q)
      PH_SYNC1: begin
        if (byte_i == SYNC_SECOND) begin
          phase_d = PH_HEADER;
          idx_d   = 3'd2;
          len_d   = '0;
        end else if (byte_i != SYNC_FIRST) begin
          phase_d = PH_HUNT;
        end
      end
      PH_HEADER: begin
        if (idx_q == 3'd2) begin
          type_d = byte_i;
        end else if (idx_q inside {[3'd3:3'd6]}) begin
          len_d = len_q | len_part;
        end else begin
          nlen_d = byte_i;
        end
        if (idx_q == 3'd7) begin
          idx_d = 3'd0;
          case (type_q)
            TYPE_NAME: begin
              if (len_q[7:0] != 8'd0) begin
                phase_d = PH_NAME;
                rem_d   = {24'd0, len_q[7:0]};
              end else begin
                push.cnt = 2'd1;
                push.r0  = empty_result(KIND_NAME);
                rem_d    = '0;
                phase_d  = PH_HUNT;
              end
            end
            TYPE_CHAT: begin
              if (len_q[15:0] != 16'd0) begin
                phase_d = PH_CHAT;
                rem_d   = {16'd0, len_q[15:0]};
              end else begin
                push.cnt = 2'd1;
                push.r0  = empty_result(KIND_CHAT);
                rem_d    = '0;
                phase_d  = PH_HUNT;
              end
            end
            TYPE_FILE: begin
              if (byte_i != 8'd0) begin
                phase_d = PH_FNAME;
                rem_d   = {24'd0, byte_i};
              end else begin
                push.r0 = empty_result(KIND_FNAME);
                if (len_q != 32'd0) begin
                  push.cnt = 2'd1;
                  phase_d  = PH_CONTENT;
                  rem_d    = len_q;
                end else begin
                  push.cnt = 2'd2;
                  push.r1  = empty_result(KIND_CONTENT);
                  rem_d    = '0;
                  phase_d  = PH_HUNT;
                end
              end
            end
            default: phase_d = PH_HUNT;
          endcase
        end else begin
          idx_d = idx_q + 3'd1;
        end
      end
      PH_NAME, PH_CHAT, PH_FNAME, PH_CONTENT: begin
        rem_d              = rem_dec;
        push.cnt           = 2'd1;
        push.r0.kind       = ph_off[1:0];
        push.r0.data_byte  = byte_i;
        push.r0.last       = (rem_dec == 32'd0);
        push.r0.empty_res  = 1'b0;
        if (rem_dec == 32'd0) begin
          if (phase_q == PH_FNAME) begin
            if (len_q != 32'd0) begin
              phase_d = PH_CONTENT;
              rem_d   = len_q;
            end else begin
              push.cnt = 2'd2;
              push.r1  = empty_result(KIND_CONTENT);
              phase_d  = PH_HUNT;
            end
          end else begin
            phase_d = PH_HUNT;
          end
        end
      end
      default: begin
        phase_d = (byte_i == SYNC_FIRST) ? PH_SYNC1 : PH_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      idx_q   <= '0;
      type_q  <= '0;
      len_q   <= '0;
      nlen_q  <= '0;
      rem_q   <= '0;
    end else if (go_i) begin
      phase_q <= phase_d;
      idx_q   <= idx_d;
      type_q  <= type_d;
      len_q   <= len_d;
      nlen_q  <= nlen_d;
      rem_q   <= rem_d;
    end
  end

  always_comb begin
    push_o = push;
    if (!go_i) begin
      push_o.cnt = 2'd0;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/sld_fifo.sv =====
// Four-entry result queue: up to two writes per cycle, one read.
`timescale 1ns / 1ps
`default_nettype none

module sld_fifo (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  sld_pkg::push_t     push_i,
  output logic               room_o,
  output logic               valid_o,
  input  wire logic          pop_i,
  output sld_pkg::res_t      res_o
);
  import sld_pkg::*;

  res_t       mem_q [4];
  logic [1:0] wr_ptr_q, rd_ptr_q;
  logic [2:0] cnt_q, cnt_d;
  logic       pop;

  assign valid_o = (cnt_q != 3'd0);
  assign room_o  = (cnt_q <= 3'd2);
  assign pop     = pop_i && valid_o;
  assign res_o   = mem_q[rd_ptr_q];
  assign cnt_d   = cnt_q + {1'b0, push_i.cnt} - {2'b00, pop};

  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.r0;
    end
    if (push_i.cnt == 2'd2) begin
      mem_q[wr_ptr_q + 2'd1] <= push_i.r1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + push_i.cnt;
      rd_ptr_q <= rd_ptr_q + {1'b0, pop};
      cnt_q    <= cnt_d;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/sync_length_deframer.sv =====
// Results of a request pass through the input register and the result queue.
// Throughput: one byte per cycle while the queue has room; a byte that yields
// two results puts both in the four-entry result queue for output in turn.
// The parser waits when the queue holds more than two results.
// Reset: asynchronous, active low; clears the parser to the sync hunt and
// empties the input register and the result queue.
`timescale 1ns / 1ps
`default_nettype none

module sync_length_deframer (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] in_byte_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [1:0]      kind_o,
  output logic [7:0]      data_byte_o,
  output logic            last_o,
  output logic            empty_res_o
);
  import sld_pkg::*;

  logic       in_vld_q;
  logic [7:0] in_byte_q;
  logic       room;
  logic       go;
  push_t      push;
  res_t       res;

  assign go         = in_vld_q && room;
  assign in_stall_o = in_vld_q && !room;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_byte_q <= in_byte_i;
    end
  end

  sld_parse u_parse (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (go),
    .byte_i (in_byte_q),
    .push_o (push)
  );

  sld_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .room_o  (room),
    .valid_o (out_valid_o),
    .pop_i   (!out_stall_i),
    .res_o   (res)
  );

  assign kind_o      = res.kind;
  assign data_byte_o = res.data_byte;
  assign last_o      = res.last;
  assign empty_res_o = res.empty_res;

endmodule

`default_nettype wire

// ===== hdl/sld_checker.sv =====
// Port-level assertions for the deframer, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module sld_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_stall_o,
  input wire logic [7:0] in_byte_i,
  input wire logic       out_valid_o,
  input wire logic       out_stall_i,
  input wire logic [1:0] kind_o,
  input wire logic [7:0] data_byte_o,
  input wire logic       last_o,
  input wire logic       empty_res_o
);

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(in_byte_i))
    else $error("request changed while stalled");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(kind_o)
      && $stable(data_byte_o) && $stable(last_o) && $stable(empty_res_o))
    else $error("result changed while stalled");

  a_empty_res: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && empty_res_o |-> last_o && data_byte_o == 8'd0)
    else $error("empty result without last or with data");

  a_rst_out: assert property (@(posedge clk_i)
    $past(!rst_ni) |-> !out_valid_o)
    else $error("result offered right after reset");

  a_rst_in: assert property (@(posedge clk_i)
    $past(!rst_ni) |-> !in_stall_o)
    else $error("input stalled right after reset");

endmodule

bind sync_length_deframer sld_checker u_sld_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_byte_i   (in_byte_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .kind_o      (kind_o),
  .data_byte_o (data_byte_o),
  .last_o      (last_o),
  .empty_res_o (empty_res_o)
);

`default_nettype wire

// ===== verif/sync_length_deframer_checker.sv =====
// Checker for the sync/length deframer: predicts payload results and compares them.
`timescale 1ns / 1ps

module sync_length_deframer_checker (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  input  wire logic       in_stall_i,
  input  wire logic [7:0] in_byte_i,
  input  wire logic       out_valid_i,
  input  wire logic       out_stall_i,
  input  wire logic [1:0] kind_i,
  input  wire logic [7:0] data_byte_i,
  input  wire logic       last_i,
  input  wire logic       empty_res_i,
  output int              mismatch_cnt_o,
  output int              outstanding_o
);
  import sld_pkg::*;

  typedef enum logic [2:0] {
    PH_HUNT, PH_SYNC1, PH_HEADER, PH_NAME, PH_CHAT, PH_FNAME, PH_CONTENT
  } parse_phase_e;

  localparam logic [2:0] HDR_TYPE    = 3'd2;
  localparam logic [2:0] HDR_LEN_LO  = 3'd3;
  localparam logic [2:0] HDR_LEN_HI  = 3'd6;
  localparam logic [2:0] HDR_NAMELEN = 3'd7;

  parse_phase_e phase;
  logic [2:0]   hdr_idx;
  logic [7:0]   frame_kind;
  logic [31:0]  size_le;
  logic [7:0]   fname_len;
  logic [31:0]  left;
  res_t         payload_q[$];
  int           mismatches = 0;

  function automatic logic [1:0] kind_of(input parse_phase_e ph);
    case (ph)
      PH_NAME:  return KIND_NAME;
      PH_CHAT:  return KIND_CHAT;
      PH_FNAME: return KIND_FNAME;
      default:  return KIND_CONTENT;
    endcase
  endfunction

  task automatic push_res(input logic [1:0] k, input logic [7:0] d, input logic l,
                          input logic e);
    res_t r;
    r.kind      = k;
    r.data_byte = d;
    r.last      = l;
    r.empty_res = e;
    payload_q.push_back(r);
  endtask

  // zero-length section gives one empty result; an empty filename opens content (empty too if size 0)
  task automatic open_section(input parse_phase_e ph, input logic [31:0] len);
    if (len != 0) begin
      phase = ph;
      left  = len;
    end else begin
      push_res(kind_of(ph), 8'h00, 1'b1, 1'b1);
      left = '0;
      if (ph == PH_FNAME) begin
        if (size_le != 0) begin
          phase = PH_CONTENT;
          left  = size_le;
        end else begin
          push_res(KIND_CONTENT, 8'h00, 1'b1, 1'b1);
          phase = PH_HUNT;
        end
      end else begin
        phase = PH_HUNT;
      end
    end
  endtask

  task automatic parse_byte(input logic [7:0] b);
    case (phase)
      PH_SYNC1: begin
        if (b == SYNC_SECOND) begin
          phase   = PH_HEADER;
          hdr_idx = HDR_TYPE;
          size_le = '0;
        end else if (b != SYNC_FIRST) begin
          phase = PH_HUNT;
        end
      end
      PH_HEADER: begin
        if (hdr_idx == HDR_TYPE) begin
          frame_kind = b;
        end else if (hdr_idx inside {[HDR_LEN_LO:HDR_LEN_HI]}) begin
          size_le = size_le | (32'(b) << (8 * (hdr_idx - HDR_LEN_LO)));
        end else begin
          fname_len = b;
        end
        if (hdr_idx == HDR_NAMELEN) begin
          hdr_idx = '0;
          case (frame_kind)
            TYPE_NAME: open_section(PH_NAME, {24'h0, size_le[7:0]});
            TYPE_CHAT: open_section(PH_CHAT, {16'h0, size_le[15:0]});
            TYPE_FILE: open_section(PH_FNAME, {24'h0, fname_len});
            default:   phase = PH_HUNT;
          endcase
        end else begin
          hdr_idx = hdr_idx + 3'd1;
        end
      end
      PH_NAME, PH_CHAT, PH_FNAME, PH_CONTENT: begin
        left = left - 1;
        push_res(kind_of(phase), b, left == 0, 1'b0);
        if (left == 0) begin
          if (phase == PH_FNAME) open_section(PH_CONTENT, size_le);
          else phase = PH_HUNT;
        end
      end
      default: phase = (b == SYNC_FIRST) ? PH_SYNC1 : PH_HUNT;
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    res_t want;
    if (!rst_ni) begin
      phase      = PH_HUNT;
      hdr_idx    = '0;
      frame_kind = '0;
      size_le    = '0;
      fname_len  = '0;
      left       = '0;
      payload_q.delete();
      outstanding_o <= 0;
    end else begin
      if (in_valid_i && !in_stall_i) parse_byte(in_byte_i);
      if (out_valid_i && !out_stall_i) begin
        if (payload_q.size() == 0) begin
          $error("unexpected result: kind %0d data_byte %02h last %0b empty_res %0b",
                 kind_i, data_byte_i, last_i, empty_res_i);
          mismatches++;
        end else begin
          want = payload_q.pop_front();
          if (kind_i !== want.kind) begin
            $error("kind: expected %0d, actual %0d", want.kind, kind_i);
            mismatches++;
          end
          if (data_byte_i !== want.data_byte) begin
            $error("data_byte: expected %02h, actual %02h", want.data_byte, data_byte_i);
            mismatches++;
          end
          if (last_i !== want.last) begin
            $error("last: expected %0b, actual %0b", want.last, last_i);
            mismatches++;
          end
          if (empty_res_i !== want.empty_res) begin
            $error("empty_res: expected %0b, actual %0b", want.empty_res, empty_res_i);
            mismatches++;
          end
        end
      end
      outstanding_o <= payload_q.size();
    end
    mismatch_cnt_o <= mismatches;
  end

endmodule

// ===== verif/sync_length_deframer_tb.sv =====
// Testbench top for the sync/length deframer: stimulus, idling phases and verdict.
`timescale 1ns / 1ps

module sync_length_deframer_tb;
  import sld_pkg::*;

  localparam int NUM_ITEMS   = 1650;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 8;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic [7:0] in_byte_i   = 8'h00;
  logic       out_stall_i = 1'b0;
  logic       in_stall_o;
  logic       out_valid_o;
  logic [1:0] kind_o;
  logic [7:0] data_byte_o;
  logic       last_o;
  logic       empty_res_o;

  int mismatch_cnt;
  int outstanding;
  int cycle_cnt    = 0;
  int snd_idle_pct = 0;
  int rcv_idle_pct = 0;
  int sent         = 0;
  int long_chats   = 0;

  sync_length_deframer u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_byte_i   (in_byte_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .kind_o      (kind_o),
    .data_byte_o (data_byte_o),
    .last_o      (last_o),
    .empty_res_o (empty_res_o)
  );

  sync_length_deframer_checker u_chk (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_i     (in_stall_o),
    .in_byte_i      (in_byte_i),
    .out_valid_i    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .kind_i         (kind_o),
    .data_byte_i    (data_byte_o),
    .last_i         (last_o),
    .empty_res_i    (empty_res_o),
    .mismatch_cnt_o (mismatch_cnt),
    .outstanding_o  (outstanding)
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt   <= cycle_cnt + 1;
    out_stall_i <= ($urandom_range(99) < rcv_idle_pct);
  end

  initial begin
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("CHECK FAILED");
    $finish;
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_byte_i  <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // hold off requests until every expected result has come out
  task automatic quiesce();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
  endtask

  task automatic send_frame();
    logic [7:0] hdr [2:7];
    logic [7:0] b;
    int sel;
    int npay;
    sel = $urandom_range(99);
    for (int i = 3; i <= 7; i++) hdr[i] = 8'($urandom);
    if ($urandom_range(99) < 15) begin
      repeat ($urandom_range(1, 3)) begin
        b = 8'($urandom);
        if (b == SYNC_FIRST) b = 8'h00;
        send_byte(b);
        sent++;
      end
    end
    if ($urandom_range(99) < 10) begin
      send_byte(SYNC_FIRST);
      b = 8'($urandom);
      if (b == SYNC_FIRST || b == SYNC_SECOND) b = b ^ 8'h0F;
      send_byte(b);
      sent += 2;
    end
    if (sel < 10) begin
      hdr[2] = 8'($urandom);
      if (hdr[2] == TYPE_NAME || hdr[2] == TYPE_CHAT || hdr[2] == TYPE_FILE)
        hdr[2] = hdr[2] | 8'h80;
      npay = 0;
    end else if (sel < 40) begin
      hdr[2] = TYPE_NAME;
      hdr[3] = ($urandom_range(24) == 0) ? 8'($urandom_range(40)) : 8'($urandom_range(8));
      npay   = int'(hdr[3]);
    end else if (sel < 70) begin
      hdr[2] = TYPE_CHAT;
      hdr[3] = 8'($urandom_range(8));
      hdr[4] = (long_chats == 0 || $urandom_range(14) == 0) ? 8'd1 : 8'd0;
      if (hdr[4] != 0) long_chats++;
      npay = int'({hdr[4], hdr[3]});
    end else begin
      hdr[2] = TYPE_FILE;
      hdr[3] = 8'($urandom_range(6));
      hdr[4] = ($urandom_range(39) == 0) ? 8'd1 : 8'd0;
      hdr[5] = 8'h00;
      hdr[6] = 8'h00;
      hdr[7] = 8'($urandom_range(5));
      npay   = int'(hdr[7]) + int'({hdr[4], hdr[3]});
    end
    if ($urandom_range(3) == 0) begin
      send_byte(SYNC_FIRST);
      sent++;
    end
    send_byte(SYNC_FIRST);
    send_byte(SYNC_SECOND);
    for (int i = 2; i <= 7; i++) send_byte(hdr[i]);
    repeat (npay) send_byte(8'($urandom));
    sent += 8 + npay;
  endtask

  initial begin
    logic [7:0] directed [$];
    int target;
    directed = '{SYNC_FIRST, SYNC_FIRST, SYNC_SECOND, TYPE_NAME,
                 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                 SYNC_FIRST, 8'h13,
                 SYNC_FIRST, SYNC_SECOND, TYPE_FILE,
                 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                 SYNC_FIRST, SYNC_SECOND, 8'hFE,
                 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (directed[i]) send_byte(directed[i]);
    sent = directed.size();
    quiesce();
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin snd_idle_pct = 0;  rcv_idle_pct = 0;  end
        1: begin snd_idle_pct = 54; rcv_idle_pct = 0;  end
        2: begin snd_idle_pct = 0;  rcv_idle_pct = 54; end
        default: begin snd_idle_pct = 38; rcv_idle_pct = 38; end
      endcase
      target = directed.size() + NUM_ITEMS * (p + 1) / 4;
      while (sent < target) send_frame();
      quiesce();
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_cnt == 0 && outstanding == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
